>>> src/cmfs_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the cube-map face selector.
// Used by cmfs_divider and cubemap_face_select; depends on nothing else.
package cmfs_pkg;

   localparam int COMP_W      = 16;                       // direction component width
   localparam int COORD_W     = 16;                       // texture coordinate width, Q0.COORD_W
   localparam int NUM_W       = COMP_W + 1;               // holds sc + m and 2m
   localparam int DIV_STAGES  = COORD_W + 1;              // divider register stages
   localparam int IN_TDATA_W  = ((3 * COMP_W + 7) / 8) * 8;
   localparam int FACE_W      = 3;
   localparam int OUT_FIELD_W = FACE_W + 2 * COORD_W;
   localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

   typedef enum logic [FACE_W-1:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   // Per-word fields that ride alongside the divider pipeline.
   typedef struct packed {
      face_type face;
      logic     invalid;
   } side_type;

endpackage

>>> src/cmfs_divider.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: floor(num * 2^COORD_W / den) for num <= den, saturated.
// One quotient bit per stage; depends on cmfs_pkg.
module cmfs_divider (
   input  logic                          clock,
   input  logic                          en,
   input  logic [cmfs_pkg::NUM_W-1:0]    num_i,
   input  logic [cmfs_pkg::NUM_W-1:0]    den_i,
   output logic [cmfs_pkg::COORD_W-1:0]  quot_o
);
   import cmfs_pkg::*;

   logic [NUM_W-1:0]   rem_ff  [0:COORD_W-1];
   logic [NUM_W-1:0]   den_ff  [0:COORD_W-1];
   logic [COORD_W-1:0] quot_ff [0:COORD_W];
   logic               sat_ff  [0:COORD_W];

   logic               sat_in;
   logic [NUM_W-1:0]   rem0_in;

   // Leading stage: a set integer bit means the quotient is exactly 1.0.
   assign sat_in  = (num_i >= den_i);
   assign rem0_in = sat_in ? (num_i - den_i) : num_i;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem0_in;
         den_ff[0]  <= den_i;
         quot_ff[0] <= '0;
         sat_ff[0]  <= sat_in;
      end
   end

   for (genvar k = 1; k <= COORD_W; k++) begin : g_step
      logic [NUM_W:0]     shift_in;
      logic [NUM_W:0]     diff_in;
      logic               take_in;
      logic [NUM_W-1:0]   rem_in;
      logic [COORD_W-1:0] quot_in;

      assign shift_in = {rem_ff[k-1], 1'b0};
      assign diff_in  = shift_in - {1'b0, den_ff[k-1]};
      assign take_in  = (shift_in >= {1'b0, den_ff[k-1]});
      assign rem_in   = take_in ? diff_in[NUM_W-1:0] : shift_in[NUM_W-1:0];
      assign quot_in  = {quot_ff[k-1][COORD_W-2:0], take_in};

      always_ff @(posedge clock) begin
         if (en) begin
            quot_ff[k] <= quot_in;
            sat_ff[k]  <= sat_ff[k-1];
         end
      end

      if (k < COORD_W) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_ff[k-1];
            end
         end
      end
   end

   assign quot_o = sat_ff[COORD_W] ? '1 : quot_ff[COORD_W];

endmodule

>>> src/cubemap_face_select.sv
`timescale 1ns / 1ps
// Cube-map face selector top level: major-axis pick, face coordinates, two dividers.
// Depends on cmfs_pkg and cmfs_divider.
//
// Usage:
//   The req_ channel carries one direction vector per word (three signed
//   components). The rsp_ channel returns one word per vector: the selected
//   face, the u and v coordinates in unsigned Q0.16, and an invalid flag in
//   tuser for the all-zero vector (which reports face +X and zero coordinates).
//   From acceptance to rsp_tvalid a vector passes one stage for magnitudes and
//   compares, one for the face table and the numerators, COORD_W + 1 divider
//   stages (one quotient bit each), and the output register. Throughput is one
//   vector per clock while rsp_tready does not stall the output; the two
//   pipelined dividers set the depth, not the rate.
//   The whole pipeline advances together. When the receiver holds rsp_tready
//   low with a word waiting, req_tready drops in the same cycle and every
//   stage holds its contents; nothing is dropped or repeated.
//   A synchronous reset clears all valid bits; the block takes words in the
//   first cycle after reset is released.
module cubemap_face_select (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cmfs_pkg::IN_TDATA_W-1:0]   req_tdata,   // dir_x, dir_y, dir_z
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cmfs_pkg::OUT_TDATA_W-1:0]  rsp_tdata,   // face, tex_u, tex_v, zero fill
   output logic                              rsp_tuser    // invalid
);
   import cmfs_pkg::*;

   logic adv;

   // ---------------- Stage A: magnitudes and major-axis compares
   logic [COMP_W-1:0] dir_x, dir_y, dir_z;
   logic [COMP_W-1:0] ax_in, ay_in, az_in;
   logic              xmaj_in, ymaj_in;

   logic              a_vld_ff;
   logic [COMP_W-1:0] a_x_ff, a_y_ff, a_z_ff;
   logic [COMP_W-1:0] a_ax_ff, a_ay_ff, a_az_ff;
   logic              a_xmaj_ff, a_ymaj_ff;

   assign dir_x = req_tdata[COMP_W-1:0];
   assign dir_y = req_tdata[2*COMP_W-1:COMP_W];
   assign dir_z = req_tdata[3*COMP_W-1:2*COMP_W];

   // The magnitude of the most negative value fits unsigned in COMP_W bits.
   assign ax_in   = dir_x[COMP_W-1] ? COMP_W'(~dir_x + 1'b1) : dir_x;
   assign ay_in   = dir_y[COMP_W-1] ? COMP_W'(~dir_y + 1'b1) : dir_y;
   assign az_in   = dir_z[COMP_W-1] ? COMP_W'(~dir_z + 1'b1) : dir_z;
   assign xmaj_in = (ax_in >= ay_in) && (ax_in >= az_in);
   assign ymaj_in = (ay_in >= az_in);

   // ---------------- Stage B: face table, numerators and divisor
   logic signed [COMP_W:0]   ex, ey, ez, nx, ny, nz;
   logic signed [COMP_W:0]   sc, tc;
   logic [COMP_W-1:0]        mag;
   face_type                 face_in;
   logic signed [COMP_W+1:0] sum_u, sum_v;

   logic              b_vld_ff;
   side_type          b_side_ff;
   logic [NUM_W-1:0]  b_num_u_ff, b_num_v_ff, b_den_ff;

   assign ex = signed'({a_x_ff[COMP_W-1], a_x_ff});
   assign ey = signed'({a_y_ff[COMP_W-1], a_y_ff});
   assign ez = signed'({a_z_ff[COMP_W-1], a_z_ff});
   assign nx = -ex;
   assign ny = -ey;
   assign nz = -ez;

   always_comb begin
      if (a_xmaj_ff) begin
         mag = a_ax_ff;
         tc  = ny;
         if (a_x_ff[COMP_W-1]) begin
            face_in = FACE_NEG_X;
            sc      = ez;
         end else begin
            face_in = FACE_POS_X;
            sc      = nz;
         end
      end else if (a_ymaj_ff) begin
         mag = a_ay_ff;
         sc  = ex;
         if (a_y_ff[COMP_W-1]) begin
            face_in = FACE_NEG_Y;
            tc      = nz;
         end else begin
            face_in = FACE_POS_Y;
            tc      = ez;
         end
      end else begin
         mag = a_az_ff;
         tc  = ny;
         if (a_z_ff[COMP_W-1]) begin
            face_in = FACE_NEG_Z;
            sc      = nx;
         end else begin
            face_in = FACE_POS_Z;
            sc      = ex;
         end
      end
   end

   // sc + m lies in [0, 2m], so it fits unsigned in NUM_W bits.
   assign sum_u = {sc[COMP_W], sc} + signed'({2'b00, mag});
   assign sum_v = {tc[COMP_W], tc} + signed'({2'b00, mag});

   // ---------------- Divider stages with the sideband line
   logic [COORD_W-1:0] quot_u, quot_v;
   logic               d_vld_ff  [0:DIV_STAGES-1];
   side_type           d_side_ff [0:DIV_STAGES-1];

   cmfs_divider u_div_u (
      .clock  (clock),
      .en     (adv),
      .num_i  (b_num_u_ff),
      .den_i  (b_den_ff),
      .quot_o (quot_u)
   );

   cmfs_divider u_div_v (
      .clock  (clock),
      .en     (adv),
      .num_i  (b_num_v_ff),
      .den_i  (b_den_ff),
      .quot_o (quot_v)
   );

   // ---------------- Output register
   logic               rsp_tvalid_ff;
   face_type           face_ff;
   logic [COORD_W-1:0] tex_u_ff, tex_v_ff;
   logic               invalid_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = OUT_TDATA_W'({tex_v_ff, tex_u_ff, face_ff});
   assign rsp_tuser  = invalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff      <= 1'b0;
         b_vld_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < DIV_STAGES; i++) begin
            d_vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         a_vld_ff    <= req_tvalid;
         b_vld_ff    <= a_vld_ff;
         d_vld_ff[0] <= b_vld_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            d_vld_ff[i] <= d_vld_ff[i-1];
         end
         rsp_tvalid_ff <= d_vld_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_x_ff    <= dir_x;
         a_y_ff    <= dir_y;
         a_z_ff    <= dir_z;
         a_ax_ff   <= ax_in;
         a_ay_ff   <= ay_in;
         a_az_ff   <= az_in;
         a_xmaj_ff <= xmaj_in;
         a_ymaj_ff <= ymaj_in;

         b_side_ff.face    <= face_in;
         b_side_ff.invalid <= (mag == '0);
         b_num_u_ff        <= sum_u[NUM_W-1:0];
         b_num_v_ff        <= sum_v[NUM_W-1:0];
         b_den_ff          <= {mag, 1'b0};

         d_side_ff[0] <= b_side_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            d_side_ff[i] <= d_side_ff[i-1];
         end

         // A zero vector divides by zero; its coordinates are forced to zero.
         face_ff    <= d_side_ff[DIV_STAGES-1].face;
         invalid_ff <= d_side_ff[DIV_STAGES-1].invalid;
         tex_u_ff   <= d_side_ff[DIV_STAGES-1].invalid ? '0 : quot_u;
         tex_v_ff   <= d_side_ff[DIV_STAGES-1].invalid ? '0 : quot_v;
      end
   end

   // ---------------- Assertions
   a_num_range: assert property (@(posedge clock) disable iff (reset)
      b_vld_ff |-> (b_num_u_ff <= b_den_ff) && (b_num_v_ff <= b_den_ff))
      else $error("face coordinate numerator exceeds twice the major magnitude");

   a_invalid_den: assert property (@(posedge clock) disable iff (reset)
      b_vld_ff |-> (b_side_ff.invalid == (b_den_ff == '0)))
      else $error("invalid flag disagrees with a zero divisor");

   a_invalid_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && invalid_ff |->
         (face_ff == FACE_POS_X) && (tex_u_ff == '0) && (tex_v_ff == '0))
      else $error("zero vector result is not face +X with zero coordinates");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      !adv && b_vld_ff |=> b_vld_ff && $stable(b_den_ff) && $stable(b_num_u_ff))
      else $error("pipeline stage changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid_ff && !a_vld_ff && !b_vld_ff)
      else $error("valid bits not cleared by reset");

endmodule

>>> tb/cubemap_face_select_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for cubemap_face_select: streams direction vectors in and
// checks every face, u, v and invalid word. Depends on cmfs_pkg and cubemap_face_select.
module cubemap_face_select_test;
   import cmfs_pkg::*;

   localparam int U_LO = FACE_W;
   localparam int V_LO = FACE_W + COORD_W;
   localparam int RANDOM_COUNT = 1000;

   typedef logic signed [COMP_W-1:0] component_type;

   typedef struct {
      component_type x;
      component_type y;
      component_type z;
      bit            quiet;   // no idling on either side while this vector is in flight
      bit            drain;   // marker: hold the sender until all lookups have returned
   } vector_type;

   typedef struct {
      face_type             face;
      logic [COORD_W-1:0]   u;
      logic [COORD_W-1:0]   v;
      logic                 invalid;
   } lookup_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [IN_TDATA_W-1:0]   req_tdata = '0;   // dir_x, dir_y, dir_z
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [OUT_TDATA_W-1:0]  rsp_tdata;        // face, tex_u, tex_v, zero fill
   logic                    rsp_tuser;        // invalid

   vector_type  vectors_to_send[$];
   lookup_type  awaited_lookups[$];
   int          mismatch_count = 0;
   int          send_gap = 0;
   int          receive_stall = 0;
   bit          quiet_now = 1'b0;

   cubemap_face_select DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Truncated (sc + m) / 2m in Q0.COORD_W; exactly 1.0 saturates to all ones.
   function automatic logic [COORD_W-1:0] face_coord(input longint sc, input longint m);
      longint q;
      if (m == 0) return '0;
      q = ((sc + m) << COORD_W) / (2 * m);
      if (q > (1 << COORD_W) - 1) q = (1 << COORD_W) - 1;
      return q[COORD_W-1:0];
   endfunction

   function automatic lookup_type lookup_face(input component_type x, input component_type y,
                                              input component_type z);
      longint sx, sy, sz, ax, ay, az, sc, tc, m;
      lookup_type r;
      sx = x;
      sy = y;
      sz = z;
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      az = (sz < 0) ? -sz : sz;
      if (ax >= ay && ax >= az) begin
         m = ax;
         tc = -sy;
         if (sx < 0) begin
            r.face = FACE_NEG_X;
            sc = sz;
         end else begin
            r.face = FACE_POS_X;
            sc = -sz;
         end
      end else if (ay >= az) begin
         m = ay;
         sc = sx;
         if (sy < 0) begin
            r.face = FACE_NEG_Y;
            tc = -sz;
         end else begin
            r.face = FACE_POS_Y;
            tc = sz;
         end
      end else begin
         m = az;
         tc = -sy;
         if (sz < 0) begin
            r.face = FACE_NEG_Z;
            sc = -sx;
         end else begin
            r.face = FACE_POS_Z;
            sc = sx;
         end
      end
      r.u = face_coord(sc, m);
      r.v = face_coord(tc, m);
      r.invalid = (m == 0);
      return r;
   endfunction

   // Signed component of a given magnitude; +32768 does not fit and is clipped.
   function automatic component_type signed_component(input int mag, input bit neg);
      if (!neg && mag > 32767) mag = 32767;
      return neg ? component_type'(-mag) : component_type'(mag);
   endfunction

   function automatic component_type random_component(input int kind, input int limit);
      case (kind)
         0: return component_type'($urandom);
         1: return component_type'($urandom_range(0, 16) - 8);
         2: begin
            case ($urandom_range(0, 5))
               0: return component_type'(-32768);
               1: return component_type'(-32767);
               2: return component_type'(-1);
               3: return component_type'(0);
               4: return component_type'(1);
               default: return component_type'(32767);
            endcase
         end
         3: return signed_component($urandom_range(0, limit), 1'($urandom_range(0, 1)));
         default: return component_type'($signed(component_type'($urandom)) >>>
                                         $urandom_range(0, 15));
      endcase
   endfunction

   task automatic add_vector(input int x, input int y, input int z, input bit quiet);
      vector_type it;
      it.x = component_type'(x);
      it.y = component_type'(y);
      it.z = component_type'(z);
      it.quiet = quiet;
      it.drain = 1'b0;
      vectors_to_send.push_back(it);
   endtask

   task automatic add_drain();
      vector_type it;
      it = '{default: 0};
      it.drain = 1'b1;
      vectors_to_send.push_back(it);
   endtask

   task automatic add_random_vector(input bit quiet);
      vector_type it;
      int mag;
      int axis;
      component_type c[3];
      it.quiet = quiet;
      it.drain = 1'b0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: foreach (c[i]) c[i] = random_component(0, 0);
         4: foreach (c[i]) c[i] = random_component(1, 0);
         5: begin
            // Equal magnitudes on two or three axes exercise the tie order.
            mag = $urandom_range(1, 32768);
            foreach (c[i]) c[i] = signed_component(mag, 1'($urandom_range(0, 1)));
            axis = $urandom_range(0, 2);
            if ($urandom_range(0, 1)) c[axis] = random_component(3, mag);
         end
         6: foreach (c[i]) c[i] = random_component(2, 0);
         7: begin
            // One dominant axis, the others anywhere up to its magnitude.
            mag = $urandom_range(1, 32768);
            axis = $urandom_range(0, 2);
            foreach (c[i]) c[i] = random_component(3, mag);
            c[axis] = signed_component(mag, 1'($urandom_range(0, 1)));
         end
         default: foreach (c[i]) c[i] = random_component(4, 0);
      endcase
      it.x = c[0];
      it.y = c[1];
      it.z = c[2];
      vectors_to_send.push_back(it);
   endtask

   // Sender: one word on req_ at a time, with random gaps and drain points.
   always @(posedge clock) begin
      logic                  next_valid;
      logic [IN_TDATA_W-1:0] next_data;
      vector_type            it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         next_valid = req_tvalid;
         next_data = req_tdata;
         if (req_tvalid && req_tready) begin
            awaited_lookups.push_back(lookup_face(req_tdata[COMP_W-1:0],
                                                  req_tdata[2*COMP_W-1:COMP_W],
                                                  req_tdata[3*COMP_W-1:2*COMP_W]));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (vectors_to_send.size() > 0) begin
               if (vectors_to_send[0].drain) begin
                  if (awaited_lookups.size() == 0) void'(vectors_to_send.pop_front());
               end else if (!vectors_to_send[0].quiet && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(0, 9);
               end else begin
                  it = vectors_to_send.pop_front();
                  quiet_now = it.quiet;
                  next_valid = 1'b1;
                  next_data = '0;
                  next_data[3*COMP_W-1:0] = {it.z, it.y, it.x};
               end
            end
         end
         req_tvalid <= next_valid;
         req_tdata <= next_data;
      end
   end

   // Receiver: random stalls on rsp_tready, every accepted word checked in order.
   always @(posedge clock) begin
      lookup_type got;
      lookup_type want;
      logic       next_ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.face = face_type'(rsp_tdata[FACE_W-1:0]);
            got.u = rsp_tdata[U_LO +: COORD_W];
            got.v = rsp_tdata[V_LO +: COORD_W];
            got.invalid = rsp_tuser;
            if (awaited_lookups.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected word face=%0d u=%0d v=%0d invalid=%0d",
                           $realtime, got.face, got.u, got.v, got.invalid);
            end else begin
               want = awaited_lookups.pop_front();
               if (got.face !== want.face || got.u !== want.u || got.v !== want.v ||
                   got.invalid !== want.invalid) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: face/u/v/invalid expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                              $realtime, want.face, want.u, want.v, want.invalid,
                              got.face, got.u, got.v, got.invalid);
               end
            end
         end
         if (receive_stall > 0) begin
            receive_stall--;
            next_ready = 1'b0;
         end else if (!quiet_now && $urandom_range(0, 6) == 0) begin
            receive_stall = $urandom_range(0, 9);
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_tready <= next_ready;
      end
   end

   initial begin
      // Zero vector, full-scale axes and the most negative value on each axis.
      add_vector(0, 0, 0, 0);
      add_vector(32767, 0, 0, 0);
      add_vector(-32768, 0, 0, 0);
      add_vector(0, 32767, 0, 0);
      add_vector(0, -32768, 0, 0);
      add_vector(0, 0, 32767, 0);
      add_vector(0, 0, -32768, 0);
      // Ties: x wins over y and z, y wins over z.
      add_vector(5, 5, 5, 0);
      add_vector(-5, 5, 0, 0);
      add_vector(0, 7, -7, 0);
      add_vector(3, -9, 9, 0);
      add_vector(-32768, -32768, -32768, 0);
      add_vector(-1, -1, -1, 0);
      add_vector(32767, -32768, 32767, 0);
      add_vector(-32768, 32767, -32767, 0);
      // Coordinates at exactly 1.0 (saturated) and 0.0, and the midpoint.
      add_vector(100, -100, -100, 0);
      add_vector(100, 100, 100, 0);
      add_vector(1, 0, 0, 0);
      add_vector(-200, 200, 200, 0);
      add_vector(-50, 300, 300, 0);
      add_vector(50, -300, -300, 0);
      add_vector(-400, 400, 400, 0);
      add_vector(400, -400, -1000, 0);
      add_vector(12345, -23456, 30000, 0);
      add_drain();
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if (i == RANDOM_COUNT / 2) add_drain();
         add_random_vector((i >= 400 && i < 500) || i >= RANDOM_COUNT - 150);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (vectors_to_send.size() != 0 || req_tvalid || awaited_lookups.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("cubemap_face_select_test: done, clean");
      end else begin
         $display("cubemap_face_select_test: done, errors");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("cubemap_face_select_test: done, errors");
      $finish;
   end

endmodule
